// ===== src/b64se_pkg.sv =====
// Package: shared types, register indexes and the sextet-to-character map.
package b64se_pkg;

   localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [1:0] CSR_CHAR_62  = 2'd0;
   localparam logic [1:0] CSR_CHAR_63  = 2'd1;
   localparam logic [1:0] CSR_PAD_CHAR = 2'd2;

   localparam logic [7:0] RESET_CHAR_62  = 8'd43;
   localparam logic [7:0] RESET_CHAR_63  = 8'd47;
   localparam logic [7:0] RESET_PAD_CHAR = 8'd61;

   // How many real bytes a group carries.
   typedef enum logic [1:0] {
      GRP_ONE  = 2'd1,
      GRP_TWO  = 2'd2,
      GRP_FULL = 2'd3
   } grp_kind_type;

   typedef struct packed {
      grp_kind_type kind;
      logic [7:0]   byte0;
      logic [7:0]   byte1;
      logic [7:0]   byte2;
   } group_type;

   // Queue write side, front to queue.
   typedef struct packed {
      logic      push;
      group_type grp;
   } grp_push_type;

   function automatic logic [7:0] map_sextet(input logic [5:0] v,
                                             input logic [7:0] c62,
                                             input logic [7:0] c63);
      logic [7:0] r;
      r = 8'd0;
      if (v < 6'd26) begin
         r = 8'd65 + {2'b00, v};
      end else if (v < 6'd52) begin
         r = 8'd71 + {2'b00, v};        // 97 + (v - 26)
      end else if (v < 6'd62) begin
         r = {2'b00, v} - 8'd4;         // 48 + (v - 52)
      end else if (v == 6'd62) begin
         r = c62;
      end else begin
         r = c63;
      end
      return r;
   endfunction

endpackage

// ===== src/b64se_front.sv =====
// Front: takes input transactions, holds pending bytes, forms groups for the queue.
module b64se_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_push,
   input  logic                    in_action,
   input  logic [7:0]              in_data_byte,
   input  logic                    q_full,
   output b64se_pkg::grp_push_type q_wr
);
   import b64se_pkg::*;

   logic [7:0] held0_ff, held0_in;
   logic [7:0] held1_ff, held1_in;
   logic [1:0] count_ff, count_in;
   logic       accept;

   assign accept = in_push && !q_full;

   always_comb begin
      held0_in       = held0_ff;
      held1_in       = held1_ff;
      count_in       = count_ff;
      q_wr.push      = 1'b0;
      q_wr.grp.kind  = GRP_FULL;
      q_wr.grp.byte0 = held0_ff;
      q_wr.grp.byte1 = held1_ff;
      q_wr.grp.byte2 = in_data_byte;
      if (accept) begin
         if (!in_action) begin
            if (count_ff == 2'd0) begin
               held0_in = in_data_byte;
               count_in = 2'd1;
            end else if (count_ff == 2'd1) begin
               held1_in = in_data_byte;
               count_in = 2'd2;
            end else begin
               q_wr.push = 1'b1;
               count_in  = 2'd0;
            end
         end else if (count_ff != 2'd0) begin
            // flush: pad out the partial group
            q_wr.push     = 1'b1;
            q_wr.grp.kind = (count_ff == 2'd1) ? GRP_ONE : GRP_TWO;
            count_in      = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      held0_ff <= held0_in;
      held1_ff <= held1_in;
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

// ===== src/b64se_queue.sv =====
// Group queue between front and back.
module b64se_queue #(
   parameter int unsigned Depth = b64se_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  b64se_pkg::grp_push_type wr,
   output logic                    full,
   input  logic                    pop,
   output b64se_pkg::group_type    head,
   output logic                    empty
);
   import b64se_pkg::*;

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);

   group_type           entry_ff [Depth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign full    = (count_ff == CntW'(Depth));
   assign empty   = (count_ff == '0);
   assign do_push = wr.push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wr.grp;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== src/b64se_back.sv =====
// Back: alphabet registers and the character emitter with its output register.
module b64se_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [7:0]           csr_wdata,
   input  b64se_pkg::group_type head,
   input  logic                 q_empty,
   output logic                 q_pop,
   output logic                 out_valid,
   output logic [7:0]           out_char,
   output logic                 out_last,
   input  logic                 out_pop
);
   import b64se_pkg::*;

   logic [7:0] char62_ff;
   logic [7:0] char63_ff;
   logic [7:0] pad_ff;
   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] char_ff, char_in;
   logic       last_ff, last_in;
   logic       load;
   logic [5:0] sextet;
   logic       use_pad;

   assign load = !q_empty && (!valid_ff || out_pop);
   assign q_pop = load && (idx_ff == 2'd3);

   always_comb begin
      sextet  = 6'd0;
      use_pad = 1'b0;
      unique case (idx_ff)
         2'd0: sextet = head.byte0[7:2];
         2'd1: sextet = {head.byte0[1:0],
                         (head.kind == GRP_ONE) ? 4'd0 : head.byte1[7:4]};
         2'd2: begin
            sextet  = {head.byte1[3:0],
                       (head.kind == GRP_FULL) ? head.byte2[7:6] : 2'd0};
            use_pad = (head.kind == GRP_ONE);
         end
         2'd3: begin
            sextet  = head.byte2[5:0];
            use_pad = (head.kind != GRP_FULL);
         end
         default: sextet = 6'd0;
      endcase
   end

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      if (load) begin
         idx_in   = idx_ff + 1'b1;
         valid_in = 1'b1;
         char_in  = use_pad ? pad_ff : map_sextet(sextet, char62_ff, char63_ff);
         last_in  = (idx_ff == 2'd3);
      end else if (out_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      last_ff <= last_in;
      if (reset) begin
         idx_ff    <= 2'd0;
         valid_ff  <= 1'b0;
         char62_ff <= RESET_CHAR_62;
         char63_ff <= RESET_CHAR_63;
         pad_ff    <= RESET_PAD_CHAR;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
         if (csr_we) begin
            // unused index: write is dropped
            unique case (csr_index)
               CSR_CHAR_62:  char62_ff <= csr_wdata;
               CSR_CHAR_63:  char63_ff <= csr_wdata;
               CSR_PAD_CHAR: pad_ff    <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   assign out_valid = valid_ff;
   assign out_char  = char_ff;
   assign out_last  = last_ff;

endmodule

// ===== src/base64_stream_encoder.sv =====
// Top level: Base64 stream encoder with configurable tail characters and pad.
//
//   channel | handshake        | payload                    | direction
//   --------+------------------+----------------------------+----------
//   req     | req_push/req_full| req_action, req_data_byte  | in
//   rsp     | rsp_pop/rsp_empty| rsp_out_char, rsp_last     | out
//   csr     | csr_we           | csr_index, csr_wdata       | in
//
// Flow: the emitter sends one character per cycle while the queue holds a group
//   and rsp_pop takes each character; a group of three bytes becomes four
//   characters, so the sustained input rate is set by the emitter.
// Reset: synchronous; clears held count, queue, character index and output valid
//   flag, and loads '+', '/' and '=' into the alphabet registers.
// Stalls: req_full rises when the group queue is full; a withheld rsp_pop stalls
//   only the output register, bytes keep arriving until the queue fills.
module base64_stream_encoder #(
   parameter int unsigned QueueDepth = b64se_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   // request side
   input  logic       req_push,
   output logic       req_full,
   input  logic       req_action,
   input  logic [7:0] req_data_byte,
   // response side
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_char,
   output logic       rsp_last,
   // register writes
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);
   import b64se_pkg::*;

   grp_push_type q_wr;
   group_type    q_head;
   logic         q_full;
   logic         q_empty;
   logic         q_pop;
   logic         out_valid;

   // front: byte holding and group formation
   b64se_front u_front (
      .clock        (clock),
      .reset        (reset),
      .in_push      (req_push),
      .in_action    (req_action),
      .in_data_byte (req_data_byte),
      .q_full       (q_full),
      .q_wr         (q_wr)
   );

   // decoupling queue of complete or padded groups
   b64se_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .wr    (q_wr),
      .full  (q_full),
      .pop   (q_pop),
      .head  (q_head),
      .empty (q_empty)
   );

   // back: four characters per group, one per cycle while rsp_pop takes them
   b64se_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .head      (q_head),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .out_valid (out_valid),
      .out_char  (rsp_out_char),
      .out_last  (rsp_last),
      .out_pop   (rsp_pop)
   );

   // conservative: input held off whenever the queue has no room
   assign req_full  = q_full;
   assign rsp_empty = !out_valid;

endmodule
